@@ rtl/swlu_pkg.sv @@
// shared types and constants for the soil worm lattice update unit
`timescale 1ns / 1ps
package swlu_pkg;

  localparam int CELL_W = 3;
  localparam int PROB_W = 17;
  localparam int FRAC_W = 16;
  localparam int COORD_IN_W = 8;
  localparam int REG_IDX_W = 2;

  localparam logic [CELL_W-1:0] CELL_EMPTY    = 3'd0;
  localparam logic [CELL_W-1:0] CELL_NUTRIENT = 3'd1;
  localparam logic [CELL_W-1:0] CELL_SOIL     = 3'd2;
  localparam logic [CELL_W-1:0] CELL_WORM     = 3'd3;
  localparam logic [CELL_W-1:0] CELL_PARASITE = 3'd4;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_SOIL     = 3'd1;
  localparam logic [2:0] KIND_EMPTY    = 3'd2;
  localparam logic [2:0] KIND_NUTRIENT = 3'd3;
  localparam logic [2:0] KIND_WORM     = 3'd4;
  localparam logic [2:0] KIND_PARASITE = 3'd5;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_SOIL_FILL      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEATH          = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WORM_BREED     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PARASITE_BREED = 2'd3;

  localparam logic [PROB_W-1:0] SOIL_FILL_RST      = 17'd32768;
  localparam logic [PROB_W-1:0] DEATH_RST          = 17'd655;
  localparam logic [PROB_W-1:0] WORM_BREED_RST     = 17'd8192;
  localparam logic [PROB_W-1:0] PARASITE_BREED_RST = 17'd65536;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_EXEC   = 2'b10
  } state_t;

endpackage

@@ rtl/soil_worm_lattice_update_unit.sv @@
// top level: toroidal lattice memory with read-modify-write update logic
//
// usage: load items (req_type high) write cell_value into the site; update
// items read the site and its chosen neighbour, apply soil fill, death, move,
// breeding or swap, and write both cells back. every item gives one result
// on the output channel (production_kind, site_after, neighbour_after).
// configuration: cfg_index/cfg_data, always ready; write only while idle.
// the input transfer latches the item and reads both cells; the result is
// computed and the site written in the exec state, and out_valid rises as
// the result is registered there. the lattice memory takes each item through
// the registered read of both cells and then the compute and site write, and
// takes no new item during the latter; the neighbour write goes out in the
// following accept cycle, with forwarding to a read of the same cell in that cycle.
// stall: while a result waits under out_stall no new item is taken; the
// output register keeps its payload until the transfer.
// reset: control and probability registers reset; lattice contents are
// undefined until loaded, and no clearing pass is run.
`timescale 1ns / 1ps
module soil_worm_lattice_update_unit #(
  parameter int SIDE = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic [swlu_pkg::COORD_IN_W-1:0]       site_row,
  input  logic [swlu_pkg::COORD_IN_W-1:0]       site_col,
  input  logic                                  nbr_axis,
  input  logic                                  nbr_dir,
  input  logic [swlu_pkg::FRAC_W-1:0]           rand_a,
  input  logic [swlu_pkg::FRAC_W-1:0]           rand_b,
  input  logic [swlu_pkg::CELL_W-1:0]           cell_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            production_kind,
  output logic [swlu_pkg::CELL_W-1:0]           site_after,
  output logic [swlu_pkg::CELL_W-1:0]           neighbour_after,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swlu_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [swlu_pkg::PROB_W-1:0]           cfg_data
);
  import swlu_pkg::*;

  localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int ROWS_IN = 1 << COORD_IN_W;

  // probability registers
  logic [PROB_W-1:0] soil_fill_prob, death_prob, worm_breed_prob, parasite_breed_prob;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      soil_fill_prob      <= SOIL_FILL_RST;
      death_prob          <= DEATH_RST;
      worm_breed_prob     <= WORM_BREED_RST;
      parasite_breed_prob <= PARASITE_BREED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOIL_FILL:      soil_fill_prob      <= cfg_data;
        REG_DEATH:          death_prob          <= cfg_data;
        REG_WORM_BREED:     worm_breed_prob     <= cfg_data;
        REG_PARASITE_BREED: parasite_breed_prob <= cfg_data;
        default:            soil_fill_prob      <= soil_fill_prob;
      endcase
    end
  end

  // coordinate reduction table, constant per SIDE
  logic [CW-1:0] mod_tab [ROWS_IN];
  for (genvar g = 0; g < ROWS_IN; g++) begin : g_mod
    assign mod_tab[g] = CW'(g % SIDE);
  end

  logic [CW-1:0] row_m, col_m, row_n, col_n, step_src, step_res;
  logic [AW-1:0] s_addr_in, n_addr_in;

  always_comb begin
    row_m = mod_tab[site_row];
    col_m = mod_tab[site_col];
    step_src = nbr_axis ? col_m : row_m;
    if (nbr_dir) begin
      step_res = (step_src == CW'(SIDE - 1)) ? '0 : step_src + CW'(1);
    end else begin
      step_res = (step_src == '0) ? CW'(SIDE - 1) : step_src - CW'(1);
    end
    row_n = nbr_axis ? row_m : step_res;
    col_n = nbr_axis ? step_res : col_m;
    s_addr_in = AW'(row_m) * AW'(SIDE) + AW'(col_m);
    n_addr_in = AW'(row_n) * AW'(SIDE) + AW'(col_n);
  end

  // control
  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != ST_ACCEPT) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: if (accept) state_next = ST_EXEC;
      ST_EXEC:   state_next = ST_ACCEPT;
      default:   state_next = ST_ACCEPT;
    endcase
  end

  // latched item
  logic              req_q;
  logic [FRAC_W-1:0] ra_q, rb_q;
  logic [CELL_W-1:0] load_q;
  logic [AW-1:0]     s_addr, n_addr;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      ra_q   <= rand_a;
      rb_q   <= rand_b;
      load_q <= cell_value;
      s_addr <= s_addr_in;
      n_addr <= n_addr_in;
    end
  end

  // pending neighbour write-back
  logic              pend_v;
  logic [AW-1:0]     pend_addr;
  logic [CELL_W-1:0] pend_data;

  // lattice memory: one write port, two registered read ports
  logic [CELL_W-1:0] lattice [DEPTH];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [CELL_W-1:0] rd_s, rd_n;
  logic [CELL_W-1:0] site_new, nbr_new;

  always_comb begin
    wr_en   = (state == ST_EXEC) || (state == ST_ACCEPT && pend_v);
    wr_addr = (state == ST_EXEC) ? s_addr : pend_addr;
    wr_data = (state == ST_EXEC) ? site_new : pend_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lattice[wr_addr] <= wr_data;
    end
    rd_s <= lattice[s_addr_in];
    rd_n <= lattice[n_addr_in];
  end

  // forwarding of the write-back that shares the read cycle
  logic              fwd_s, fwd_n;
  logic [CELL_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    fwd_s    <= pend_v && (state == ST_ACCEPT) && (pend_addr == s_addr_in);
    fwd_n    <= pend_v && (state == ST_ACCEPT) && (pend_addr == n_addr_in);
    fwd_data <= pend_data;
  end

  // update rules
  logic [CELL_W-1:0] sv, nv;
  logic [2:0]        kind;
  logic [PROB_W-1:0] rho;
  logic              para;

  always_comb begin
    sv       = fwd_s ? fwd_data : rd_s;
    nv       = fwd_n ? fwd_data : rd_n;
    site_new = sv;
    nbr_new  = nv;
    kind     = KIND_NONE;
    para     = (sv == CELL_PARASITE);
    rho      = para ? parasite_breed_prob : worm_breed_prob;
    if (req_q == REQ_LOAD) begin
      site_new = load_q;
    end else if (sv == CELL_EMPTY || sv == CELL_NUTRIENT) begin
      if (nv == CELL_SOIL && {1'b0, ra_q} < soil_fill_prob) begin
        site_new = CELL_SOIL;
        kind     = KIND_SOIL;
      end
    end else if (sv == CELL_WORM || sv == CELL_PARASITE) begin
      if ({1'b0, ra_q} < death_prob) begin
        site_new = CELL_EMPTY;
        kind     = KIND_EMPTY;
      end else begin
        nbr_new  = sv;
        site_new = CELL_EMPTY;
        if (nv == CELL_NUTRIENT) begin
          if ({1'b0, rb_q} < rho) begin
            site_new = sv;
            kind     = para ? KIND_PARASITE : KIND_WORM;
          end else begin
            kind = KIND_EMPTY;
          end
        end else if (nv == CELL_SOIL) begin
          if (para) begin
            kind = KIND_EMPTY;
          end else begin
            site_new = CELL_NUTRIENT;
            kind     = KIND_NUTRIENT;
          end
        end else if (nv == CELL_WORM || nv == CELL_PARASITE) begin
          site_new = nv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC) begin
        pend_v    <= 1'b1;
        out_valid <= 1'b1;
      end else begin
        pend_v <= 1'b0;
        if (!out_stall) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      pend_addr       <= n_addr;
      pend_data       <= nbr_new;
      production_kind <= kind;
      site_after      <= site_new;
      neighbour_after <= nbr_new;
    end
  end

endmodule

@@ rtl/swlu_checker.sv @@
// port-level assertions for the lattice update unit, bound to the top level
`timescale 1ns / 1ps
module swlu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       req_type,
  input logic [2:0] cell_value,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] production_kind,
  input logic [2:0] site_after
);
  import swlu_pkg::*;

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // every input transfer shows a result once the exec state has registered it
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("no result after input transfer");

  // the memory cycle blocks a second transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during read-modify-write");

  // a load reports the loaded value and no production
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_LOAD |-> ##2
      (site_after == $past(cell_value, 2) && production_kind == KIND_NONE))
    else $error("load result mismatch");

  // production code stays within its defined range
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> production_kind <= KIND_PARASITE)
    else $error("production kind out of range");

endmodule

bind soil_worm_lattice_update_unit swlu_checker u_swlu_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .req_type        (req_type),
  .cell_value      (cell_value),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .production_kind (production_kind),
  .site_after      (site_after)
);
